// ===== rtl/core/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared constants, codes and types of the round-robin tick scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

	localparam int NUM_JOBS   = 16;
	localparam int RING_DEPTH = 16;
	localparam int JOB_AW     = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;

	localparam int ID_W     = 4;
	localparam int BURST_W  = 8;
	localparam int STATUS_W = 3;
	localparam int TICK_W   = 16;
	localparam int QUANT_W  = 8;
	localparam int CFG_IW   = 1;
	localparam int CFG_DW   = 16;

	localparam logic [QUANT_W-1:0] QUANTUM_RST    = QUANT_W'(3);
	localparam logic [TICK_W-1:0]  TICK_LIMIT_RST = TICK_W'(49);

	typedef enum logic [STATUS_W-1:0] {
		ST_RAN      = 3'd0,
		ST_IDLE     = 3'd1,
		ST_STOPPED  = 3'd2,
		ST_ADMITTED = 3'd3,
		ST_REJECTED = 3'd4
	} status_t;

	typedef enum logic {
		REQ_ADMIT = 1'b0,
		REQ_TICK  = 1'b1
	} req_type_t;

	typedef enum logic [CFG_IW-1:0] {
		CFG_QUANTUM    = 1'b0,
		CFG_TICK_LIMIT = 1'b1
	} cfg_index_t;

	// Control broadcast to every entry of the run queue.
	typedef struct packed {
		logic            pop;
		logic            push;
		logic [ID_W-1:0] push_id;
	} q_ctrl_t;

	// Queue status seen by the control logic.
	typedef struct packed {
		logic            head_valid;
		logic [ID_W-1:0] head_id;
		logic            full;
	} q_stat_t;

	// Job id to burst table slot: id modulo NUM_JOBS by repeated subtraction.
	function automatic logic [JOB_AW-1:0] burst_slot(input logic [ID_W-1:0] id);
		logic [ID_W:0] v;
		v = {1'b0, id};
		for (int i = 0; i < 8; i++) begin
			if (int'(v) >= NUM_JOBS) begin
				v = v - (ID_W+1)'(NUM_JOBS);
			end
		end
		return JOB_AW'(v);
	endfunction

endpackage

// ===== rtl/core/rrts_req_if.sv =====
// ----------------------------------------------------------------------------
// rrts_req_if
// Request channel: admit and tick words.
// ----------------------------------------------------------------------------
interface rrts_req_if;
	import rrts_pkg::*;

	logic               valid;
	logic               ready;
	logic               req_type;
	logic [ID_W-1:0]    job_id;
	logic [BURST_W-1:0] burst;

	modport source (output valid, output req_type, output job_id, output burst, input ready);
	modport sink (input valid, input req_type, input job_id, input burst, output ready);
endinterface

// ===== rtl/core/rrts_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rrts_rsp_if
// Result channel: one word per request.
// ----------------------------------------------------------------------------
interface rrts_rsp_if;
	import rrts_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     run_id;
	logic [BURST_W-1:0]  remaining;
	logic                finished;
	logic                rotated;
	logic [TICK_W-1:0]   tick_number;

	modport source (output valid, output status, output run_id, output remaining,
		output finished, output rotated, output tick_number, input ready);
	modport sink (input valid, input status, input run_id, input remaining,
		input finished, input rotated, input tick_number, output ready);
endinterface

// ===== rtl/core/rrts_cfg_if.sv =====
// ----------------------------------------------------------------------------
// rrts_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface rrts_cfg_if;
	import rrts_pkg::*;

	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] index;
	logic [CFG_DW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rrts_entry.sv =====
// ----------------------------------------------------------------------------
// rrts_entry
// One run queue entry: shifts toward the head on pop, takes a pushed id
// when it becomes the first free entry.
// ----------------------------------------------------------------------------
module rrts_entry (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rrts_pkg::q_ctrl_t         ctrl,
	input  logic                      left_valid,
	input  logic                      right_valid,
	input  logic [rrts_pkg::ID_W-1:0] right_id,
	output logic                      valid,
	output logic [rrts_pkg::ID_W-1:0] id
);
	import rrts_pkg::*;

	logic            valid_q;
	logic [ID_W-1:0] id_q;
	logic            shift_valid;
	logic [ID_W-1:0] shift_id;
	logic            land;

	always_comb begin
		shift_valid = ctrl.pop ? right_valid : valid_q;
		shift_id    = ctrl.pop ? right_id : id_q;
		// take the push where the tail lands after the optional shift
		land = ctrl.push && (ctrl.pop ? (valid_q && !right_valid) : (!valid_q && left_valid));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= shift_valid || land;
		end
	end

	always_ff @(posedge clk) begin
		id_q <= land ? ctrl.push_id : shift_id;
	end

	assign valid = valid_q;
	assign id    = id_q;
endmodule

// ===== rtl/core/rrts_queue.sv =====
// ----------------------------------------------------------------------------
// rrts_queue
// Run queue as a row of entries, head at entry 0.
// ----------------------------------------------------------------------------
module rrts_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  rrts_pkg::q_ctrl_t ctrl,
	output rrts_pkg::q_stat_t stat
);
	import rrts_pkg::*;

	logic [RING_DEPTH-1:0] ent_valid;
	logic [ID_W-1:0]       ent_id [RING_DEPTH];

	for (genvar k = 0; k < RING_DEPTH; k++) begin : g_ent
		logic            lv;
		logic            rv;
		logic [ID_W-1:0] rid;

		if (k == 0) begin : g_first
			assign lv = 1'b1;
		end else begin : g_mid
			assign lv = ent_valid[k-1];
		end

		if (k == RING_DEPTH-1) begin : g_last
			assign rv  = 1'b0;
			assign rid = '0;
		end else begin : g_inner
			assign rv  = ent_valid[k+1];
			assign rid = ent_id[k+1];
		end

		rrts_entry u_entry (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.left_valid  (lv),
			.right_valid (rv),
			.right_id    (rid),
			.valid       (ent_valid[k]),
			.id          (ent_id[k])
		);
	end

	always_comb begin
		stat.head_valid = ent_valid[0];
		stat.head_id    = ent_id[0];
		stat.full       = ent_valid[RING_DEPTH-1];
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> ent_valid[0])
		else $error("pop on empty run queue");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.push && !ctrl.pop) |-> !ent_valid[RING_DEPTH-1])
		else $error("push on full run queue");

	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((ent_valid >> 1) & ~ent_valid) == '0)
		else $error("run queue entries not packed toward head");
endmodule

// ===== rtl/core/round_robin_tick_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// round_robin_tick_scheduler_top
// Round-robin time-slice scheduler with tick count and tick limit.
// ----------------------------------------------------------------------------
// A result word is registered by the execute step that follows the take of its
//   request word, later while the previous result word still waits to be taken.
// A new request word is taken only after the current one executes: a take step,
//   then an execute step on the registered burst read of the current head.
// Reset (arst_n low): run queue empty, slice and tick counts zero,
//   quantum 3, tick limit 49; the burst table is not cleared.
// ----------------------------------------------------------------------------
module round_robin_tick_scheduler_top (
	input logic         clk,
	input logic         arst_n,
	rrts_req_if.sink    req_ch,
	rrts_rsp_if.source  rsp_ch,
	rrts_cfg_if.sink    cfg_ch
);
	import rrts_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;

	// captured request word
	logic               req_type_q;
	logic [ID_W-1:0]    job_id_q;
	logic [BURST_W-1:0] burst_q;

	// configuration
	logic [QUANT_W-1:0] quantum_q;
	logic [TICK_W-1:0]  tick_limit_q;

	// scheduler counters
	logic [QUANT_W-1:0] slice_q;
	logic [TICK_W-1:0]  ticks_q;

	// burst table: one write and one registered read per cycle
	logic [BURST_W-1:0] burst_mem_q [NUM_JOBS];
	logic [BURST_W-1:0] burst_rd_q;
	logic               mem_we;
	logic [JOB_AW-1:0]  mem_waddr;
	logic [BURST_W-1:0] mem_wdata;

	// result register
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [ID_W-1:0]     run_id_q;
	logic [BURST_W-1:0]  remaining_q;
	logic                finished_q;
	logic                rotated_q;

	q_ctrl_t q_ctrl;
	q_stat_t q_stat;

	logic               req_take;
	logic               do_exec;
	logic [TICK_W-1:0]  ticks_n;
	logic [QUANT_W-1:0] slice_n;
	logic [QUANT_W-1:0] slice_next;
	logic [BURST_W-1:0] rem_n;
	logic               fin_n;
	logic               leave;
	status_t            status_n;
	logic [ID_W-1:0]    run_id_n;
	logic [BURST_W-1:0] remaining_n;
	logic               rotated_n;

	// Accept a request only when no item is in flight; the result register
	// keeps the output side decoupled.
	assign req_ch.ready = (state_q == S_IDLE);
	assign req_take     = req_ch.valid && req_ch.ready;
	// Execute once the result register is free or being drained.
	assign do_exec      = (state_q == S_EXEC) && (!rsp_valid_q || rsp_ch.ready);

	// Configuration always taken; the user must write only while idle, not enforced here.
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q    <= QUANTUM_RST;
			tick_limit_q <= TICK_LIMIT_RST;
		end else if (cfg_ch.valid) begin
			case (cfg_index_t'(cfg_ch.index))
				CFG_QUANTUM:    quantum_q <= cfg_ch.data[QUANT_W-1:0];
				CFG_TICK_LIMIT: tick_limit_q <= cfg_ch.data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Execute step: decide the result and the state update.
	always_comb begin
		ticks_n     = (ticks_q == '1) ? ticks_q : ticks_q + TICK_W'(1);
		slice_n     = (slice_q == '1) ? slice_q : slice_q + QUANT_W'(1);
		// a head already at zero burst does no work but still leaves
		rem_n       = (burst_rd_q != '0) ? burst_rd_q - BURST_W'(1) : '0;
		fin_n       = (rem_n == '0);
		leave       = fin_n || (slice_n >= quantum_q);

		status_n    = ST_IDLE;
		run_id_n    = '0;
		remaining_n = '0;
		rotated_n   = 1'b0;
		slice_next  = slice_q;
		mem_we      = 1'b0;
		mem_waddr   = burst_slot(job_id_q);
		mem_wdata   = burst_q;
		q_ctrl      = '0;

		if (req_type_q == REQ_ADMIT) begin
			run_id_n = job_id_q;
			if ((burst_q == '0) || q_stat.full) begin
				status_n = ST_REJECTED;
			end else begin
				status_n       = ST_ADMITTED;
				remaining_n    = burst_q;
				mem_we         = do_exec;
				q_ctrl.push    = do_exec;
				q_ctrl.push_id = job_id_q;
			end
		end else if ((tick_limit_q != '0) && (ticks_n >= tick_limit_q)) begin
			status_n = ST_STOPPED;
		end else if (!q_stat.head_valid) begin
			status_n = ST_IDLE;
		end else begin
			status_n       = ST_RAN;
			run_id_n       = q_stat.head_id;
			remaining_n    = rem_n;
			rotated_n      = leave && !fin_n;
			slice_next     = leave ? '0 : slice_n;
			mem_we         = do_exec;
			mem_waddr      = burst_slot(q_stat.head_id);
			mem_wdata      = rem_n;
			// leave the head; re-queue at the tail if burst is left
			q_ctrl.pop     = do_exec && leave;
			q_ctrl.push    = do_exec && leave && !fin_n;
			q_ctrl.push_id = q_stat.head_id;
		end
	end

	rrts_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (q_ctrl),
		.stat   (q_stat)
	);

	// Burst table: read follows the head every cycle, so the value is ready
	// in the execute state that follows the take of the request word.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			burst_mem_q[mem_waddr] <= mem_wdata;
		end
		burst_rd_q <= burst_mem_q[burst_slot(q_stat.head_id)];
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			req_type_q <= req_ch.req_type;
			job_id_q   <= req_ch.job_id;
			burst_q    <= req_ch.burst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			slice_q     <= '0;
			ticks_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_take) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (do_exec) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (do_exec) begin
				rsp_valid_q <= 1'b1;
				slice_q     <= slice_next;
				if (req_type_q == REQ_TICK) begin
					ticks_q <= ticks_n;
				end
			end else if (rsp_ch.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result word until taken.
	always_ff @(posedge clk) begin
		if (do_exec) begin
			status_q    <= status_n;
			run_id_q    <= run_id_n;
			remaining_q <= remaining_n;
			finished_q  <= (status_n == ST_RAN) && fin_n;
			rotated_q   <= rotated_n;
		end
	end

	assign rsp_ch.valid       = rsp_valid_q;
	assign rsp_ch.status      = status_q;
	assign rsp_ch.run_id      = run_id_q;
	assign rsp_ch.remaining   = remaining_q;
	assign rsp_ch.finished    = finished_q;
	assign rsp_ch.rotated     = rotated_q;
	assign rsp_ch.tick_number = ticks_q;

	a_slice_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		(slice_q != '0) |-> q_stat.head_valid)
		else $error("slice count running with empty queue");

	a_exec_follows_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> (state_q == S_EXEC))
		else $error("taken request word not executed");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (status_q == ST_RAN || status_q == ST_IDLE ||
			status_q == ST_STOPPED || status_q == ST_ADMITTED ||
			status_q == ST_REJECTED))
		else $error("result status out of range");

	a_flags_only_on_run: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q != ST_RAN) |-> (!finished_q && !rotated_q))
		else $error("finished or rotated set on a non-run result");
endmodule
